[rtl/bcbd_pkg.sv]
// ----------------------------------------------------------------------------
// bcbd_pkg
// Shared types and codes for the banked cartridge bus decoder.
// ----------------------------------------------------------------------------
package bcbd_pkg;

  localparam int BANK_COUNT = 4;
  localparam int BANK_W     = $clog2(BANK_COUNT);

  // bus access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // read data sources
  localparam logic [1:0] SRC_CONST = 2'd0;
  localparam logic [1:0] SRC_FLASH = 2'd1;
  localparam logic [1:0] SRC_SD    = 2'd2;

  // configuration register indexes
  localparam logic CFG_EXPANDER_EN = 1'b0;
  localparam logic CFG_FLASH_WE    = 1'b1;

  localparam logic [7:0]  SUBSLOT_MAPPER = 8'h03;
  localparam logic [1:0]  SUBSLOT_FIXED  = 2'd1;
  localparam logic [15:0] SUBSLOT_ADDR   = 16'hFFFF;
  localparam logic [7:0]  BYTE_ONES      = 8'hFF;
  localparam logic [7:0]  BANK1_RESET    = 8'h01;

  // bank 1 comes up as 1, every other bank as 0
  localparam logic [BANK_COUNT-1:0][7:0] BANK_RESET =
    {{(BANK_COUNT-2){8'h00}}, BANK1_RESET, 8'h00};

  typedef struct packed {
    logic        opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    logic [1:0]  read_source;
    logic [7:0]  read_value;
    logic [19:0] flash_address;
    logic        flash_write_strobe;
    logic        sd_strobe;
    logic [7:0]  sd_out_byte;
    logic        sd_chip_select_high;
    logic        sd_card_index;
  } result_t;

  typedef struct packed {
    logic expander_enable;
    logic flash_write_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0]                  subslot_select;
    logic [BANK_COUNT-1:0][7:0]  bank;
    logic                        card_select;
  } mapper_state_t;

endpackage

[rtl/bcbd_decode.sv]
// ----------------------------------------------------------------------------
// bcbd_decode
// Decodes one bus access against the mapper state: result fields and the
// state that the access leaves behind.
// ----------------------------------------------------------------------------
module bcbd_decode (
  input  bcbd_pkg::item_t         item,
  input  bcbd_pkg::cfg_t          cfg,
  input  bcbd_pkg::mapper_state_t st,
  output bcbd_pkg::result_t       res,
  output bcbd_pkg::mapper_state_t st_nxt
);
  import bcbd_pkg::*;

  logic              wr;
  logic [15:0]       a;
  logic [7:0]        d;
  logic              sub_hit;
  logic [7:0]        subslot_cur;
  logic [1:0]        slot;
  logic              slot3;
  logic              sd_win;
  logic              flash_win;
  logic [BANK_W-1:0] page;
  logic [19:0]       xlate;
  logic              sd_hi;

  assign wr  = (item.opcode == OP_WRITE);
  assign a   = item.bus_address;
  assign d   = item.write_data;

  assign sub_hit     = cfg.expander_enable && (a == SUBSLOT_ADDR);
  assign subslot_cur = (sub_hit && wr) ? d : st.subslot_select;

  always_comb begin
    if (!cfg.expander_enable) begin
      slot = SUBSLOT_FIXED;
    end else begin
      case (a[15:14])
        2'd0:    slot = subslot_cur[1:0];
        2'd1:    slot = subslot_cur[3:2];
        2'd2:    slot = subslot_cur[5:4];
        2'd3:    slot = subslot_cur[7:6];
        default: slot = subslot_cur[1:0];
      endcase
    end
  end

  assign slot3     = ({6'd0, slot} == SUBSLOT_MAPPER);
  // page 0x4000 maps to bank 0, so bank = (a[14:13] - 2) mod 4
  assign page      = {~a[14], a[13]};
  assign xlate     = {st.bank[page][6:0], a[12:0]};
  assign sd_win    = (st.bank[0][7:6] == 2'b01) && (a[15:13] == 3'b010);
  assign flash_win = (a[15:14] == 2'b01) || (a[15:14] == 2'b10);
  // 0x5800-0x5FFF within the sd window is the card select register
  assign sd_hi     = a[12] & a[11];

  always_comb begin
    res    = '0;
    st_nxt = st;
    st_nxt.subslot_select = subslot_cur;
    if (sub_hit && !wr) begin
      res.read_source = SRC_CONST;
      res.read_value  = ~st.subslot_select;
    end else if (slot3) begin
      if (!wr) begin
        if (sd_win) begin
          res.read_source         = SRC_SD;
          res.sd_strobe           = 1'b1;
          res.sd_out_byte         = BYTE_ONES;
          res.sd_chip_select_high = a[12];
          res.sd_card_index       = st.card_select;
        end else if (flash_win) begin
          res.read_source   = SRC_FLASH;
          res.flash_address = xlate;
        end else begin
          res.read_value = BYTE_ONES;
        end
      end else begin
        if (sd_win) begin
          if (sd_hi) begin
            st_nxt.card_select = d[0];
          end else begin
            res.sd_strobe           = 1'b1;
            res.sd_out_byte         = d;
            res.sd_chip_select_high = a[12];
            res.sd_card_index       = st.card_select;
          end
        end
        if (flash_win && cfg.flash_write_enable && st.bank[page][7]) begin
          res.flash_address      = xlate;
          res.flash_write_strobe = 1'b1;
        end
        if (a[15:13] == 3'b011) begin
          st_nxt.bank[a[12:11]] = d;
        end
      end
    end
  end

endmodule

[rtl/banked_cartridge_bus_decoder_top.sv]
// ----------------------------------------------------------------------------
// banked_cartridge_bus_decoder_top
// Subslot expander with an 8 kB banked flash mapper and SD port in subslot 3.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tuser opcode, tdata address + data
//  out_    | out | out_tvalid/out_tready | tuser read_source, tdata strobes
//  cfg_    | in  | cfg_wr_en             | cfg_index, cfg_wdata
//
// one beat per cycle sustained while out_tready is high; a beat passes through
// the input register, the decode and the result register
// mapper state is updated as the beat leaves the input register
// rst_n is synchronous; it clears both stages and restores the registers
// a stalled result holds both stages; in_tready drops only when both are full
module banked_cartridge_bus_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // bus_address[15:0], write_data[23:16]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_value[7:0], flash_address[27:8],
                                  // flash_write_strobe[28], sd_strobe[29],
                                  // sd_out_byte[37:30], sd_chip_select_high[38],
                                  // sd_card_index[39]
  output logic [1:0]  out_tuser,  // read_source
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);
  import bcbd_pkg::*;

  logic          s1_valid_r;
  item_t         s1_item_r;
  logic          out_valid_r;
  result_t       out_res_r;
  cfg_t          cfg_r;
  mapper_state_t state_r;
  mapper_state_t state_nxt;
  result_t       res;
  logic          advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expander_enable    <= 1'b1;
      cfg_r.flash_write_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_EXPANDER_EN: cfg_r.expander_enable    <= cfg_wdata;
        CFG_FLASH_WE:    cfg_r.flash_write_enable <= cfg_wdata;
        default:         cfg_r                    <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.opcode      <= in_tuser;
      s1_item_r.bus_address <= in_tdata[15:0];
      s1_item_r.write_data  <= in_tdata[23:16];
    end
  end

  bcbd_decode u_decode (
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .st     (state_r),
    .res    (res),
    .st_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.subslot_select <= '0;
      state_r.bank           <= BANK_RESET;
      state_r.card_select    <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.read_source;
  assign out_tdata  = {out_res_r.sd_card_index, out_res_r.sd_chip_select_high,
                       out_res_r.sd_out_byte, out_res_r.sd_strobe,
                       out_res_r.flash_write_strobe, out_res_r.flash_address,
                       out_res_r.read_value};

  // flash writes never pass while write-protected
  a_flash_protect: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.flash_write_strobe |-> cfg_r.flash_write_enable)
    else $error("flash write strobe while write-protected");

  // an sd read result always carries a transfer strobe
  a_sd_read_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == SRC_SD) |-> out_res_r.sd_strobe)
    else $error("sd read result without transfer");

  // the input side only stalls when both stages are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled with a free stage");

  // mapper state moves only when a beat leaves the input register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("mapper state changed without a beat");

endmodule
